// ===== sv/radix_digit_converter_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the radix digit converter
// Shared property forms used by the converter's checks.
// ---------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rdc_pkg.sv =====
// ---------------------------------------------------------------------------
// Radix digit converter package
// Widths, limits, state encoding and the divider interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdc_pkg;

    // Widths of the value and of one digit.
    localparam int VALUE_WIDTH = 31;
    localparam int RADIX_WIDTH = 6;

    // Depth of the digit stack and the widths that follow from it.
    localparam int DIGIT_DEPTH = 32;
    localparam int DEPTH_WIDTH = $clog2(DIGIT_DEPTH + 1);
    localparam int ADDR_WIDTH  = $clog2(DIGIT_DEPTH);

    // Bit counter of the serial divider.
    localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);

    // Radix limits and reset value.
    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = RADIX_WIDTH'(2);
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = RADIX_WIDTH'(36);
    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = RADIX_WIDTH'(10);

    // Converter sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_POP,
        ST_OUT
    } state_t;

    // Request to the serial divider.
    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [RADIX_WIDTH-1:0] divisor;
    } div_req_t;

    // Result from the serial divider.
    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [RADIX_WIDTH-1:0] remainder;
    } div_res_t;

endpackage

// ===== sv/rdc_divider.sv =====
// ---------------------------------------------------------------------------
// Radix digit converter serial divider
// Restoring division of the value by the radix, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdc_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  rdc_pkg::div_req_t  req,
    output rdc_pkg::div_res_t  res
);

    logic                                running_reg;
    logic                                done_reg;
    logic [rdc_pkg::CNT_WIDTH-1:0]       cnt_reg;
    logic [rdc_pkg::VALUE_WIDTH-1:0]     q_reg;
    logic [rdc_pkg::VALUE_WIDTH-1:0]     q_next;
    logic [rdc_pkg::RADIX_WIDTH-1:0]     rem_reg;
    logic [rdc_pkg::RADIX_WIDTH-1:0]     rem_next;
    logic [rdc_pkg::RADIX_WIDTH-1:0]     divisor_reg;
    logic [rdc_pkg::RADIX_WIDTH:0]       trial;
    logic                                ge;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb
    begin
        trial = {rem_reg, q_reg[rdc_pkg::VALUE_WIDTH-1]};
        ge    = (trial >= {1'b0, divisor_reg});
        if (ge)
        begin
            rem_next = rdc_pkg::RADIX_WIDTH'(trial - {1'b0, divisor_reg});
        end
        else
        begin
            rem_next = trial[rdc_pkg::RADIX_WIDTH-1:0];
        end
        q_next = {q_reg[rdc_pkg::VALUE_WIDTH-2:0], ge};
    end

    // Control: count through the dividend bits, then flag completion.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !running_reg)
            begin
                running_reg <= 1'b1;
                cnt_reg     <= '0;
            end
            else if (running_reg)
            begin
                if (cnt_reg == rdc_pkg::CNT_WIDTH'(rdc_pkg::VALUE_WIDTH - 1))
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient shifts in where the dividend shifts out.
    always_ff @(posedge clk)
    begin
        if (req.start && !running_reg)
        begin
            q_reg       <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (running_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = q_reg;
    assign res.remainder = rem_reg;

endmodule

// ===== sv/radix_digit_converter.sv =====
// ---------------------------------------------------------------------------
// Radix digit converter
// Splits a non-negative integer into digits of a configured radix.
// ---------------------------------------------------------------------------
// Each accepted value is divided repeatedly by the radix in a bit-serial
// divider; every remainder is pushed onto a digit stack, and the stack is
// then popped so that the digits leave most significant first, with last set
// on the final one. Each digit is read from the stack in the pop state and
// held in the output state until the output takes it. A value of zero gives
// no digits. One value is converted at a time; a radix written outside 2..36
// is held at the nearer limit, and the reset radix is 10.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radix_digit_converter_defines.svh"

module radix_digit_converter
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rdc_pkg::RADIX_WIDTH-1:0] cfg_data,
    // Input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rdc_pkg::VALUE_WIDTH-1:0] value,
    // Output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rdc_pkg::RADIX_WIDTH-1:0] digit,
    output logic                            last
);

    rdc_pkg::state_t                     state_reg;
    rdc_pkg::state_t                     state_next;
    logic [rdc_pkg::DEPTH_WIDTH-1:0]     depth_reg;
    logic [rdc_pkg::DEPTH_WIDTH-1:0]     depth_next;
    logic [rdc_pkg::DEPTH_WIDTH-1:0]     depth_dec;
    logic [rdc_pkg::RADIX_WIDTH-1:0]     radix_reg;
    logic [rdc_pkg::RADIX_WIDTH-1:0]     mem [rdc_pkg::DIGIT_DEPTH];
    logic [rdc_pkg::RADIX_WIDTH-1:0]     rd_data_reg;
    logic                                wr_en;
    logic                                rd_en;
    logic                                in_accept;
    logic                                out_accept;
    rdc_pkg::div_req_t                   div_req;
    rdc_pkg::div_res_t                   div_res;

    // Bit-serial divider shared by every division of a transaction.
    rdc_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    // Radix register, clamped to the legal range when written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= rdc_pkg::RADIX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_data < rdc_pkg::RADIX_MIN)
            begin
                radix_reg <= rdc_pkg::RADIX_MIN;
            end
            else if (cfg_data > rdc_pkg::RADIX_MAX)
            begin
                radix_reg <= rdc_pkg::RADIX_MAX;
            end
            else
            begin
                radix_reg <= cfg_data;
            end
        end
    end

    // Handshake decode.
    assign in_stall   = (state_reg != rdc_pkg::ST_IDLE);
    assign cfg_ready  = (state_reg == rdc_pkg::ST_IDLE);
    assign out_valid  = (state_reg == rdc_pkg::ST_OUT);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;
    assign depth_dec  = depth_reg - 1'b1;

    // Sequencer: divide and push, then pop one digit at a time.
    always_comb
    begin
        state_next       = state_reg;
        depth_next       = depth_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = value;
        div_req.divisor  = radix_reg;
        case (state_reg)
            rdc_pkg::ST_IDLE:
            begin
                if (in_accept && (value != '0))
                begin
                    div_req.start = 1'b1;
                    state_next    = rdc_pkg::ST_DIV;
                end
            end
            rdc_pkg::ST_DIV:
            begin
                div_req.dividend = div_res.quotient;
                if (div_res.done)
                begin
                    // Digits beyond the stack depth are dropped from the top.
                    if (depth_reg < rdc_pkg::DEPTH_WIDTH'(rdc_pkg::DIGIT_DEPTH))
                    begin
                        wr_en      = 1'b1;
                        depth_next = depth_reg + 1'b1;
                    end
                    if (div_res.quotient == '0)
                    begin
                        state_next = rdc_pkg::ST_POP;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                    end
                end
            end
            rdc_pkg::ST_POP:
            begin
                rd_en      = 1'b1;
                depth_next = depth_dec;
                state_next = rdc_pkg::ST_OUT;
            end
            rdc_pkg::ST_OUT:
            begin
                if (out_accept)
                begin
                    if (depth_reg == '0)
                    begin
                        state_next = rdc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = rdc_pkg::ST_POP;
                    end
                end
            end
            default:
            begin
                state_next = rdc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdc_pkg::ST_IDLE;
            depth_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
        end
    end

    // Digit stack: one write port at the top, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[depth_reg[rdc_pkg::ADDR_WIDTH-1:0]] <= div_res.remainder;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[depth_dec[rdc_pkg::ADDR_WIDTH-1:0]];
        end
    end

    assign digit = rd_data_reg;
    assign last  = (depth_reg == '0);

    // Checks on the sequencer and the digit path.
    `RDC_ASSERT_SAME(a_digit_below_radix, out_valid, digit < radix_reg,
        "digit not below the radix")
    `RDC_ASSERT_NEXT(a_nonzero_starts_division, in_accept && (value != '0),
        state_reg == rdc_pkg::ST_DIV, "nonzero value did not start a division")
    `RDC_ASSERT_SAME(a_pop_has_digit, state_reg == rdc_pkg::ST_POP, depth_reg != '0,
        "pop from an empty digit stack")
    `RDC_ASSERT_SAME(a_done_only_in_div, div_res.done, state_reg == rdc_pkg::ST_DIV,
        "divider finished outside a conversion")

endmodule
